### rtl/rrts_pkg.sv
// Shared types, constants and helpers of the round-robin thread scheduler.
package rrts_pkg;

    localparam int THREAD_COUNT = 8;
    localparam int IDX_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int CNT_W = $clog2(THREAD_COUNT + 1);
    localparam logic [31:0] FRAME_BYTES = 32'(38 * 4);
    localparam int IN_W = 104;
    localparam int OUT_W = 48;

    typedef enum logic [2:0] {
        TS_NEW = 3'd0,
        TS_READY = 3'd1,
        TS_RUNNING = 3'd2,
        TS_WAITING = 3'd3,
        TS_TERMINATED = 3'd4
    } thr_state_t;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_YIELD = 3'd1,
        OP_CREATE = 3'd2,
        OP_WAKEUP = 3'd3,
        OP_SLEEP = 3'd4,
        OP_SLEEP_TO = 3'd5,
        OP_EXIT = 3'd6,
        OP_NONE = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        STS_OK = 3'd0,
        STS_NO_SLOT = 3'd1,
        STS_OVERFLOW = 3'd2,
        STS_FAULT = 3'd3,
        STS_HALTED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_TICK_RD,
        SQ_TICK_WR,
        SQ_SCH_HEAD,
        SQ_SCH_NXT,
        SQ_SCH_CUR,
        SQ_SCH_SW,
        SQ_SCH_SP,
        SQ_CRT_RD,
        SQ_CRT_WR,
        SQ_ONE_RD,
        SQ_ONE_WR,
        SQ_DONE
    } seq_state_t;

    typedef struct packed {
        thr_state_t  state;
        logic        sleep;
        logic        quit;
        logic [31:0] countdown;
        logic [31:0] top;
    } thr_rec_t;

    // Record of a slot that has not been written since reset
    function automatic thr_rec_t reset_rec(input logic [IDX_W-1:0] idx);
        thr_rec_t r;
        r.state = (idx == '0) ? TS_RUNNING : TS_TERMINATED;
        r.sleep = 1'b0;
        r.quit = 1'b0;
        r.countdown = '0;
        r.top = '0;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
        return (32'(v) == THREAD_COUNT - 1) ? '0 : IDX_W'(32'(v) + 1);
    endfunction

endpackage

### rtl/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler with sleep timeouts.
//
// Usage: one command beat enters on the s_ group (opcode, stack pointer,
// target thread, sleep ticks, stack base) and exactly one result beat leaves
// on the m_ group (next stack pointer, running thread, created slot, switch
// and frame flags, status). s_tready is high only while the sequencer is
// idle, so commands are handled one at a time.
// Sequencing: a tick walks every slot, reading and then writing back its
// record in the thread record memory, and then schedules; a yield only
// schedules, a create scans the slots for a terminated one, and
// wakeup/sleep/exit read and write back one record. The thread record
// memory has a registered read.
// The result sits in an output register; the next command is taken while
// it waits, and the sequencer holds in its final step until the register
// frees when the receiver stalls.
// Reset: slot 0 is running, all others terminated, the ready queue empty.
// A per-slot valid bit stands in for clearing the record memory. Faults
// (queue overflow, scheduler fault) stick until reset; later beats return
// status halted.
module round_robin_thread_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] opcode, [34:3] stack_pointer, [37:35] target_thread,
    // [69:38] sleep_ticks, [101:70] new_stack_base, [103:102] zero
    input  logic [rrts_pkg::IN_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] next_stack_pointer, [34:32] running_thread, [37:35] created_thread,
    // [38] switched, [39] needs_frame, [42:40] status, [47:43] zero
    output logic [rrts_pkg::OUT_W-1:0] m_tdata
);

    localparam int IW = rrts_pkg::IDX_W;
    localparam int CW = rrts_pkg::CNT_W;
    localparam int N = rrts_pkg::THREAD_COUNT;

    // Thread record memory and saved stack pointer memory
    rrts_pkg::thr_rec_t rec_mem [N];
    logic [31:0] ssp_mem [N];
    logic [N-1:0] rec_vld_reg;

    rrts_pkg::thr_rec_t rec_q_reg;
    logic rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [31:0] ssp_q_reg;

    logic [IW-1:0] rd_addr;
    logic rec_we;
    logic [IW-1:0] rec_waddr;
    rrts_pkg::thr_rec_t rec_wdata;
    logic ssp_we;
    logic [IW-1:0] ssp_waddr;
    logic [31:0] ssp_wdata;
    logic [IW-1:0] ssp_raddr;
    rrts_pkg::thr_rec_t rec_q;

    // Ready queue
    logic [IW-1:0] fifo_reg [N];
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic push_en;
    logic [IW-1:0] push_idx;
    logic push_ovf;

    // Sequencer state
    rrts_pkg::seq_state_t state_reg, state_next;
    rrts_pkg::opcode_t op_reg, op_next;
    logic [31:0] sp_reg, sp_next;
    logic [31:0] ticks_reg, ticks_next;
    logic [31:0] base_reg, base_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] nxt_reg, nxt_next;
    rrts_pkg::thr_rec_t nrec_reg, nrec_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic halted_reg, halted_next;

    // Result fields under construction
    logic [31:0] nsp_reg, nsp_next;
    logic [2:0] created_reg, created_next;
    logic sw_reg, sw_next;
    logic frame_reg, frame_next;
    rrts_pkg::status_t status_reg, status_next;

    logic m_tvalid_reg, m_tvalid_next;
    logic [rrts_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic out_free;
    rrts_pkg::thr_rec_t w;
    logic [31:0] new_sp;

    assign s_tready = (state_reg == rrts_pkg::SQ_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign rec_q = rd_vld_reg ? rec_q_reg : rrts_pkg::reset_rec(rd_idx_reg);
    assign push_ovf = (rrts_pkg::wrap_inc(tail_reg) == head_reg);
    assign new_sp = nrec_reg.top - rrts_pkg::FRAME_BYTES;

    // Memories: registered reads, one write port each
    always_ff @(posedge clk)
    begin
        rec_q_reg <= rec_mem[rd_addr];
        ssp_q_reg <= ssp_mem[ssp_raddr];
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (ssp_we)
        begin
            ssp_mem[ssp_waddr] <= ssp_wdata;
        end
        if (push_en)
        begin
            fifo_reg[tail_reg] <= push_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_vld_reg <= '0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
            state_reg <= rrts_pkg::SQ_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            cur_reg <= '0;
            halted_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (rec_we)
            begin
                rec_vld_reg[rec_waddr] <= 1'b1;
            end
            rd_vld_reg <= rec_vld_reg[rd_addr] || (rec_we && rec_waddr == rd_addr);
            rd_idx_reg <= rd_addr;
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            cur_reg <= cur_next;
            halted_reg <= halted_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        sp_reg <= sp_next;
        ticks_reg <= ticks_next;
        base_reg <= base_next;
        idx_reg <= idx_next;
        nxt_reg <= nxt_next;
        nrec_reg <= nrec_next;
        nsp_reg <= nsp_next;
        created_reg <= created_next;
        sw_reg <= sw_next;
        frame_reg <= frame_next;
        status_reg <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        sp_next = sp_reg;
        ticks_next = ticks_reg;
        base_next = base_reg;
        idx_next = idx_reg;
        nxt_next = nxt_reg;
        nrec_next = nrec_reg;
        cur_next = cur_reg;
        halted_next = halted_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        nsp_next = nsp_reg;
        created_next = created_reg;
        sw_next = sw_reg;
        frame_next = frame_reg;
        status_next = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        rd_addr = idx_reg[IW-1:0];
        ssp_raddr = nxt_reg;
        rec_we = 1'b0;
        rec_waddr = idx_reg[IW-1:0];
        rec_wdata = rec_q;
        ssp_we = 1'b0;
        ssp_waddr = cur_reg;
        ssp_wdata = sp_reg;
        push_en = 1'b0;
        push_idx = idx_reg[IW-1:0];
        w = rec_q;

        unique case (state_reg)
            rrts_pkg::SQ_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next = rrts_pkg::opcode_t'(s_tdata[2:0]);
                    sp_next = s_tdata[34:3];
                    ticks_next = s_tdata[69:38];
                    base_next = s_tdata[101:70];
                    nsp_next = '0;
                    created_next = '0;
                    sw_next = 1'b0;
                    frame_next = 1'b0;
                    status_next = rrts_pkg::STS_OK;
                    idx_next = '0;
                    state_next = rrts_pkg::SQ_DONE;
                    if (halted_reg)
                    begin
                        status_next = rrts_pkg::STS_HALTED;
                    end
                    else
                    begin
                        unique case (rrts_pkg::opcode_t'(s_tdata[2:0]))
                            rrts_pkg::OP_TICK:
                            begin
                                nsp_next = s_tdata[34:3];
                                state_next = rrts_pkg::SQ_TICK_RD;
                            end
                            rrts_pkg::OP_YIELD:
                            begin
                                nsp_next = s_tdata[34:3];
                                state_next = rrts_pkg::SQ_SCH_HEAD;
                            end
                            rrts_pkg::OP_CREATE:
                            begin
                                status_next = rrts_pkg::STS_NO_SLOT;
                                state_next = rrts_pkg::SQ_CRT_RD;
                            end
                            rrts_pkg::OP_WAKEUP:
                            begin
                                if (32'(s_tdata[37:35]) < 32'(N))
                                begin
                                    idx_next = CW'(s_tdata[37:35]);
                                    state_next = rrts_pkg::SQ_ONE_RD;
                                end
                            end
                            rrts_pkg::OP_SLEEP, rrts_pkg::OP_EXIT:
                            begin
                                idx_next = CW'(cur_reg);
                                state_next = rrts_pkg::SQ_ONE_RD;
                            end
                            rrts_pkg::OP_SLEEP_TO:
                            begin
                                if (s_tdata[69:38] != '0)
                                begin
                                    idx_next = CW'(cur_reg);
                                    state_next = rrts_pkg::SQ_ONE_RD;
                                end
                            end
                            default:
                            begin
                                state_next = rrts_pkg::SQ_DONE;
                            end
                        endcase
                    end
                end
            end

            rrts_pkg::SQ_TICK_RD:
            begin
                state_next = rrts_pkg::SQ_TICK_WR;
            end

            rrts_pkg::SQ_TICK_WR:
            begin
                // Count down a sleeping slot; ready it when it expires
                state_next = (32'(idx_reg) == N - 1) ? rrts_pkg::SQ_SCH_HEAD
                                                     : rrts_pkg::SQ_TICK_RD;
                idx_next = idx_reg + 1'b1;
                if (rec_q.countdown != '0 && rec_q.state == rrts_pkg::TS_WAITING)
                begin
                    w.countdown = rec_q.countdown - 32'd1;
                    rec_we = 1'b1;
                    if (w.countdown == '0)
                    begin
                        w.state = rrts_pkg::TS_READY;
                        push_en = 1'b1;
                        tail_next = rrts_pkg::wrap_inc(tail_reg);
                        if (push_ovf)
                        begin
                            halted_next = 1'b1;
                            status_next = rrts_pkg::STS_OVERFLOW;
                            state_next = rrts_pkg::SQ_DONE;
                        end
                    end
                    rec_wdata = w;
                end
            end

            rrts_pkg::SQ_SCH_HEAD:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = rrts_pkg::SQ_DONE;
                end
                else
                begin
                    nxt_next = fifo_reg[head_reg];
                    rd_addr = fifo_reg[head_reg];
                    head_next = rrts_pkg::wrap_inc(head_reg);
                    state_next = rrts_pkg::SQ_SCH_NXT;
                end
            end

            rrts_pkg::SQ_SCH_NXT:
            begin
                nrec_next = rec_q;
                rd_addr = cur_reg;
                if (rec_q.state == rrts_pkg::TS_RUNNING)
                begin
                    halted_next = 1'b1;
                    status_next = rrts_pkg::STS_FAULT;
                    state_next = rrts_pkg::SQ_DONE;
                end
                else if (rec_q.state == rrts_pkg::TS_READY || rec_q.state == rrts_pkg::TS_NEW)
                begin
                    state_next = rrts_pkg::SQ_SCH_CUR;
                end
                else
                begin
                    // stale entry: drop it
                    state_next = rrts_pkg::SQ_DONE;
                end
            end

            rrts_pkg::SQ_SCH_CUR:
            begin
                state_next = rrts_pkg::SQ_SCH_SW;
                if (rec_q.state != rrts_pkg::TS_RUNNING)
                begin
                    halted_next = 1'b1;
                    status_next = rrts_pkg::STS_FAULT;
                    state_next = rrts_pkg::SQ_DONE;
                end
                else
                begin
                    ssp_we = 1'b1;
                    rec_we = 1'b1;
                    rec_waddr = cur_reg;
                    if (rec_q.quit)
                    begin
                        w.quit = 1'b0;
                        w.state = rrts_pkg::TS_TERMINATED;
                    end
                    else if (rec_q.sleep)
                    begin
                        w.sleep = 1'b0;
                        w.state = rrts_pkg::TS_WAITING;
                    end
                    else
                    begin
                        w.state = rrts_pkg::TS_READY;
                        push_en = 1'b1;
                        push_idx = cur_reg;
                        tail_next = rrts_pkg::wrap_inc(tail_reg);
                        if (push_ovf)
                        begin
                            halted_next = 1'b1;
                            status_next = rrts_pkg::STS_OVERFLOW;
                            state_next = rrts_pkg::SQ_DONE;
                        end
                    end
                    rec_wdata = w;
                end
            end

            rrts_pkg::SQ_SCH_SW:
            begin
                w = nrec_reg;
                w.state = rrts_pkg::TS_RUNNING;
                rec_we = 1'b1;
                rec_waddr = nxt_reg;
                rec_wdata = w;
                cur_next = nxt_reg;
                sw_next = 1'b1;
                if (nrec_reg.state == rrts_pkg::TS_NEW)
                begin
                    ssp_we = 1'b1;
                    ssp_waddr = nxt_reg;
                    ssp_wdata = new_sp;
                    frame_next = 1'b1;
                    nsp_next = new_sp;
                    state_next = rrts_pkg::SQ_DONE;
                end
                else
                begin
                    state_next = rrts_pkg::SQ_SCH_SP;
                end
            end

            rrts_pkg::SQ_SCH_SP:
            begin
                nsp_next = ssp_q_reg;
                state_next = rrts_pkg::SQ_DONE;
            end

            rrts_pkg::SQ_CRT_RD:
            begin
                state_next = rrts_pkg::SQ_CRT_WR;
            end

            rrts_pkg::SQ_CRT_WR:
            begin
                if (rec_q.state == rrts_pkg::TS_TERMINATED)
                begin
                    w.state = rrts_pkg::TS_NEW;
                    w.sleep = 1'b0;
                    w.quit = 1'b0;
                    w.countdown = '0;
                    w.top = base_reg - ({30'd0, base_reg[1:0]} + 32'd4);
                    rec_we = 1'b1;
                    rec_wdata = w;
                    push_en = 1'b1;
                    tail_next = rrts_pkg::wrap_inc(tail_reg);
                    if (push_ovf)
                    begin
                        halted_next = 1'b1;
                        status_next = rrts_pkg::STS_OVERFLOW;
                    end
                    else
                    begin
                        status_next = rrts_pkg::STS_OK;
                        created_next = 3'(idx_reg);
                    end
                    state_next = rrts_pkg::SQ_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = (32'(idx_reg) == N - 1) ? rrts_pkg::SQ_DONE
                                                         : rrts_pkg::SQ_CRT_RD;
                end
            end

            rrts_pkg::SQ_ONE_RD:
            begin
                state_next = rrts_pkg::SQ_ONE_WR;
            end

            rrts_pkg::SQ_ONE_WR:
            begin
                rec_we = 1'b1;
                unique case (op_reg)
                    rrts_pkg::OP_WAKEUP:
                    begin
                        if (rec_q.state == rrts_pkg::TS_WAITING)
                        begin
                            w.state = rrts_pkg::TS_READY;
                            push_en = 1'b1;
                            tail_next = rrts_pkg::wrap_inc(tail_reg);
                            if (push_ovf)
                            begin
                                halted_next = 1'b1;
                                status_next = rrts_pkg::STS_OVERFLOW;
                            end
                        end
                    end
                    rrts_pkg::OP_SLEEP:
                    begin
                        w.sleep = 1'b1;
                    end
                    rrts_pkg::OP_SLEEP_TO:
                    begin
                        w.sleep = 1'b1;
                        w.countdown = ticks_reg;
                    end
                    rrts_pkg::OP_EXIT:
                    begin
                        w.quit = 1'b1;
                    end
                    default:
                    begin
                        rec_we = 1'b0;
                    end
                endcase
                rec_wdata = w;
                state_next = rrts_pkg::SQ_DONE;
            end

            rrts_pkg::SQ_DONE:
            begin
                // Hold here until the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = {5'd0, status_reg, frame_reg, sw_reg, created_reg,
                                    3'(cur_reg), nsp_reg};
                    state_next = rrts_pkg::SQ_IDLE;
                end
            end

            default:
            begin
                state_next = rrts_pkg::SQ_IDLE;
            end
        endcase
    end

endmodule

### tb/tb_round_robin_thread_scheduler.sv
// Self-checking testbench for the round-robin thread scheduler: directed table, then random stream.
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler;

    localparam int RANDOM_ITEMS = 1430;
    localparam int FINAL_ITEMS = 150;
    localparam int CYCLE_LIMIT = 1000000;

    // Command beat as it enters on the slave side
    typedef struct packed {
        rrts_pkg::opcode_t op;
        logic [31:0] sp;
        logic [2:0]  tgt;
        logic [31:0] ticks;
        logic [31:0] base;
    } cmd_t;

    // Result beat as it leaves on the master side
    typedef struct packed {
        logic [31:0] nsp;
        logic [2:0]  running;
        logic [2:0]  created;
        logic        switched;
        logic        frame;
        logic [2:0]  status;
    } res_t;

    // Full scheduler state kept by the predictor
    typedef struct packed {
        logic [7:0][2:0]  st;
        logic [7:0]       slp;
        logic [7:0]       ext;
        logic [7:0][31:0] cnt;
        logic [7:0][31:0] ssp;
        logic [7:0][31:0] top;
        logic [7:0][2:0]  fifo;
        logic [2:0]       head;
        logic [2:0]       tail;
        logic [2:0]       cur;
        logic             halted;
    } sched_t;

    typedef struct packed {
        cmd_t cmd;
        logic typed;
        res_t exp;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;

    sched_t   model;
    res_t     pending_results[$];
    dir_row_t dir_rows[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       cycles;
    bit       failed;

    round_robin_thread_scheduler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Push a slot on the ready ring; a full ring halts the block
    function automatic bit ring_push(inout sched_t s, input logic [2:0] slot);
        s.fifo[s.tail] = slot;
        s.tail = s.tail + 3'd1;
        if (s.tail == s.head)
        begin
            s.halted = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Dequeue one entry and switch to it when it is ready or new
    function automatic logic [2:0] pick_next(inout sched_t s, input logic [31:0] sp,
                                             output logic sw, output logic frame);
        logic [2:0] nxt;
        logic [2:0] nst;
        logic [2:0] c;
        sw = 1'b0;
        frame = 1'b0;
        if (s.head == s.tail)
            return rrts_pkg::STS_OK;
        nxt = s.fifo[s.head];
        s.head = s.head + 3'd1;
        nst = s.st[nxt];
        if (nst == rrts_pkg::TS_RUNNING)
        begin
            s.halted = 1'b1;
            return rrts_pkg::STS_FAULT;
        end
        if (nst != rrts_pkg::TS_READY && nst != rrts_pkg::TS_NEW)
            return rrts_pkg::STS_OK;  // stale entry, drop it
        c = s.cur;
        if (s.st[c] != rrts_pkg::TS_RUNNING)
        begin
            s.halted = 1'b1;
            return rrts_pkg::STS_FAULT;
        end
        s.ssp[c] = sp;
        if (s.ext[c])
        begin
            s.ext[c] = 1'b0;
            s.st[c] = rrts_pkg::TS_TERMINATED;
        end
        else if (s.slp[c])
        begin
            s.slp[c] = 1'b0;
            s.st[c] = rrts_pkg::TS_WAITING;
        end
        else
        begin
            s.st[c] = rrts_pkg::TS_READY;
            if (!ring_push(s, c))
                return rrts_pkg::STS_OVERFLOW;
        end
        if (nst == rrts_pkg::TS_NEW)
        begin
            s.ssp[nxt] = s.top[nxt] - rrts_pkg::FRAME_BYTES;
            frame = 1'b1;
        end
        s.st[nxt] = rrts_pkg::TS_RUNNING;
        s.cur = nxt;
        sw = 1'b1;
        return rrts_pkg::STS_OK;
    endfunction

    // Apply one command to the state and return the result it produces
    function automatic res_t sched_step(inout sched_t s, input cmd_t c);
        res_t r;
        logic [2:0] cur;
        r = '0;
        cur = s.cur;
        if (s.halted)
            r.status = rrts_pkg::STS_HALTED;
        else
        begin
            case (c.op)
                rrts_pkg::OP_TICK, rrts_pkg::OP_YIELD:
                begin
                    r.nsp = c.sp;
                    if (c.op == rrts_pkg::OP_TICK)
                    begin
                        for (int i = 0; i < 8 && r.status == rrts_pkg::STS_OK; i++)
                        begin
                            if (s.cnt[i] != 0 && s.st[i] == rrts_pkg::TS_WAITING)
                            begin
                                s.cnt[i] = s.cnt[i] - 1;
                                if (s.cnt[i] == 0)
                                begin
                                    s.st[i] = rrts_pkg::TS_READY;
                                    if (!ring_push(s, 3'(i)))
                                        r.status = rrts_pkg::STS_OVERFLOW;
                                end
                            end
                        end
                    end
                    if (r.status == rrts_pkg::STS_OK)
                        r.status = pick_next(s, c.sp, r.switched, r.frame);
                    if (r.switched)
                        r.nsp = s.ssp[s.cur];
                end
                rrts_pkg::OP_CREATE:
                begin
                    r.status = rrts_pkg::STS_NO_SLOT;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (s.st[i] == rrts_pkg::TS_TERMINATED)
                        begin
                            s.top[i] = c.base - ((c.base % 4) + 4);
                            s.cnt[i] = '0;
                            s.slp[i] = 1'b0;
                            s.ext[i] = 1'b0;
                            s.st[i] = rrts_pkg::TS_NEW;
                            if (ring_push(s, 3'(i)))
                            begin
                                r.status = rrts_pkg::STS_OK;
                                r.created = 3'(i);
                            end
                            else
                                r.status = rrts_pkg::STS_OVERFLOW;
                            break;
                        end
                    end
                end
                rrts_pkg::OP_WAKEUP:
                begin
                    if (s.st[c.tgt] == rrts_pkg::TS_WAITING)
                    begin
                        s.st[c.tgt] = rrts_pkg::TS_READY;
                        if (!ring_push(s, c.tgt))
                            r.status = rrts_pkg::STS_OVERFLOW;
                    end
                end
                rrts_pkg::OP_SLEEP:
                    s.slp[cur] = 1'b1;
                rrts_pkg::OP_SLEEP_TO:
                begin
                    if (c.ticks != 0)
                    begin
                        s.cnt[cur] = c.ticks;
                        s.slp[cur] = 1'b1;
                    end
                end
                rrts_pkg::OP_EXIT:
                    s.ext[cur] = 1'b1;
                default: ;
            endcase
        end
        r.running = s.cur;
        return r;
    endfunction

    function automatic cmd_t mk_cmd(rrts_pkg::opcode_t op, logic [31:0] sp, logic [2:0] tgt,
                                    logic [31:0] ticks, logic [31:0] base);
        cmd_t c;
        c.op = op;
        c.sp = sp;
        c.tgt = tgt;
        c.ticks = ticks;
        c.base = base;
        return c;
    endfunction

    // Random command; the final stretch leans on queue-filling operations
    function automatic cmd_t rand_cmd(bit fill);
        cmd_t c;
        int w;
        c.sp = $urandom;
        c.tgt = 3'($urandom_range(7));
        c.ticks = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(4));
        c.base = $urandom;
        w = $urandom_range(99);
        if (fill)
            c.op = (w < 40) ? rrts_pkg::OP_CREATE :
                   (w < 60) ? rrts_pkg::OP_WAKEUP :
                   (w < 75) ? rrts_pkg::OP_SLEEP_TO :
                   (w < 90) ? rrts_pkg::OP_TICK : rrts_pkg::OP_YIELD;
        else
            c.op = (w < 25) ? rrts_pkg::OP_TICK :
                   (w < 45) ? rrts_pkg::OP_YIELD :
                   (w < 55) ? rrts_pkg::OP_CREATE :
                   (w < 70) ? rrts_pkg::OP_WAKEUP :
                   (w < 78) ? rrts_pkg::OP_SLEEP :
                   (w < 90) ? rrts_pkg::OP_SLEEP_TO :
                   (w < 96) ? rrts_pkg::OP_EXIT : rrts_pkg::OP_NONE;
        return c;
    endfunction

    // Drive one beat, wait for acceptance, then record what it should produce
    task automatic send_cmd(cmd_t c, bit typed, res_t typed_exp);
        res_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, c.base, c.ticks, c.tgt, c.sp, c.op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = sched_step(model, c);
        pending_results.push_back(typed ? typed_exp : r);
    endtask

    // Receiver: check each result beat, then pick the next stall
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.nsp = m_tdata[31:0];
            got.running = m_tdata[34:32];
            got.created = m_tdata[37:35];
            got.switched = m_tdata[38];
            got.frame = m_tdata[39];
            got.status = m_tdata[42:40];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.nsp !== want.nsp)
                begin
                    $display("%0t: next_stack_pointer exp %h got %h", $time, want.nsp, got.nsp);
                    failed = 1'b1;
                end
                if (got.running !== want.running)
                begin
                    $display("%0t: running_thread exp %0d got %0d", $time,
                             want.running, got.running);
                    failed = 1'b1;
                end
                if (got.created !== want.created)
                begin
                    $display("%0t: created_thread exp %0d got %0d", $time,
                             want.created, got.created);
                    failed = 1'b1;
                end
                if (got.switched !== want.switched)
                begin
                    $display("%0t: switched exp %b got %b", $time, want.switched, got.switched);
                    failed = 1'b1;
                end
                if (got.frame !== want.frame)
                begin
                    $display("%0t: needs_frame exp %b got %b", $time, want.frame, got.frame);
                    failed = 1'b1;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    failed = 1'b1;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        cmd_t c;
        sched_t trial;
        res_t r;
        res_t none;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        cycles <= 0;
        failed = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        none = '0;

        model = '0;
        for (int i = 1; i < 8; i++)
            model.st[i] = rrts_pkg::TS_TERMINATED;
        model.st[0] = rrts_pkg::TS_RUNNING;

        // Directed rows; expected results typed in where they are obvious
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_YIELD, 32'hFFFF_FFFF, 0, 0, 0), 1'b1,
                            res_t'({32'hFFFF_FFFF, 3'd0, 3'd0, 1'b0, 1'b0,
                                    3'(rrts_pkg::STS_OK)})});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_TICK, 32'h0, 3'd7, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF), 1'b1,
                            res_t'({32'h0, 3'd0, 3'd0, 1'b0, 1'b0, 3'(rrts_pkg::STS_OK)})});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_CREATE, 0, 0, 0, 32'h0), 1'b1,
                            res_t'({32'h0, 3'd0, 3'd1, 1'b0, 1'b0, 3'(rrts_pkg::STS_OK)})});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_NONE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF), 1'b1, res_t'('0)});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_WAKEUP, 0, 3'd7, 0, 0), 1'b1, res_t'('0)});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_CREATE, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_SLEEP_TO, 0, 0, 32'h0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_SLEEP_TO, 0, 0, 32'h2, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_YIELD, 32'h1234_5678, 0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_TICK, 32'hA5A5_5A5A, 0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_TICK, 32'h5A5A_A5A5, 0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_EXIT, 0, 0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_YIELD, 32'h0000_1000, 0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_SLEEP, 0, 0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_WAKEUP, 0, 3'd0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_YIELD, 32'h0000_2000, 0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_WAKEUP, 0, 3'd0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_WAKEUP, 0, 3'd2, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_CREATE, 0, 0, 0, 32'h8000_0003), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_CREATE, 0, 0, 0, 32'h7FFF_FFFD), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_YIELD, 32'h0000_3000, 0, 0, 0), 1'b0, none});
        dir_rows.push_back({mk_cmd(rrts_pkg::OP_TICK, 32'h0000_4000, 0, 0, 0), 1'b0, none});

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].exp);

        // Random stream in idle/stall phases; hold off halting until the last stretch
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case (n * 4 / RANDOM_ITEMS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            c = rand_cmd(1'b0);
            trial = model;
            r = sched_step(trial, c);
            if (trial.halted)
                c.op = rrts_pkg::OP_YIELD;
            send_cmd(c, 1'b0, none);
        end
        for (int n = 0; n < FINAL_ITEMS; n++)
            send_cmd(rand_cmd(1'b1), 1'b0, none);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
